>>> src/tfsb_pkg.sv
// Shared types, constants and codes for the triangle flat shade and bounds block.
`timescale 1ns / 1ps
package tfsb_pkg;

  localparam int COORD_W   = 32;
  localparam int COLOR_W   = 16;
  localparam int LIGHT_W   = 16;
  localparam int EDGE_BITS = 24;
  localparam int NORM_BITS = 22;
  localparam int EDGE_W    = EDGE_BITS + 1;
  localparam int NORM_W    = NORM_BITS + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int SQ_W      = 2 * NORM_BITS + 2;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int DOT_W     = NORM_W + LIGHT_W + 2;
  localparam int NUM_W     = DOT_W + 1;
  localparam int Q_W       = COLOR_W + 2;
  localparam int CNT_W     = 5;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [COLOR_W:0] COS_ONE = (COLOR_W+1)'(1) << COLOR_W;

  localparam logic signed [LIGHT_W-1:0] RST_LIGHT_X = 16'sd11484;
  localparam logic signed [LIGHT_W-1:0] RST_LIGHT_Y = -16'sd14764;
  localparam logic signed [LIGHT_W-1:0] RST_LIGHT_Z = 16'sd26905;
  localparam logic [COLOR_W-1:0] RST_AMBIENT = 16'd31457;
  localparam logic [COLOR_W-1:0] RST_DIFFUSE = 16'd27525;
  localparam logic [COLOR_W-1:0] RST_RED     = 16'd47186;
  localparam logic [COLOR_W-1:0] RST_GREEN   = 16'd49807;
  localparam logic [COLOR_W-1:0] RST_BLUE    = 16'd51118;

  typedef enum logic [2:0] {
    REG_LIGHT_X, REG_LIGHT_Y, REG_LIGHT_Z, REG_AMBIENT,
    REG_DIFFUSE, REG_RED, REG_GREEN, REG_BLUE
  } reg_idx_t;

  typedef enum logic [3:0] {
    B_IDLE, B_PROD, B_CROSS, B_FIT, B_SQDOT, B_SQRT, B_DIVSET, B_DIV, B_INTEN, B_COLOR
  } back_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic signed [COORD_W-1:0] third_x;
    logic signed [COORD_W-1:0] third_y;
    logic signed [COORD_W-1:0] third_z;
    logic                      starts_new_mesh;
  } in_t;

  typedef struct packed {
    logic [COLOR_W-1:0]        shade_red;
    logic [COLOR_W-1:0]        shade_green;
    logic [COLOR_W-1:0]        shade_blue;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
  } out_t;

  typedef struct packed {
    logic signed [LIGHT_W-1:0] light_x;
    logic signed [LIGHT_W-1:0] light_y;
    logic signed [LIGHT_W-1:0] light_z;
    logic [COLOR_W-1:0]        ambient;
    logic [COLOR_W-1:0]        diffuse;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
  } cfg_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] x;
    logic signed [EDGE_W-1:0] y;
    logic signed [EDGE_W-1:0] z;
  } edge_t;

  typedef struct packed {
    edge_t                     e1;
    edge_t                     e2;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> src/tfsb_front.sv
// Front end: takes triangles, updates the running box, forms and scales the edges.
`timescale 1ns / 1ps
module tfsb_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take_i,
  input  tfsb_pkg::in_t   tri_i,
  output tfsb_pkg::job_t  job_o
);
  import tfsb_pkg::*;

  logic signed [COORD_W-1:0] lo_r [3];
  logic signed [COORD_W-1:0] hi_r [3];
  logic                      box_valid_r;
  logic signed [COORD_W-1:0] lo_nxt [3];
  logic signed [COORD_W-1:0] hi_nxt [3];
  logic signed [COORD_W-1:0] va [3];
  logic signed [COORD_W-1:0] vb [3];
  logic signed [COORD_W-1:0] vc [3];

  // common right shift so every edge magnitude drops below 2^EDGE_BITS
  function automatic edge_t fit_edge(input logic signed [COORD_W:0] x,
                                     input logic signed [COORD_W:0] y,
                                     input logic signed [COORD_W:0] z);
    logic [COORD_W:0] mx, my, mz, mm;
    logic [COORD_W:0] sx, sy, sz;
    logic [5:0]       s;
    edge_t            r;
    mx = x[COORD_W] ? -x : x;
    my = y[COORD_W] ? -y : y;
    mz = z[COORD_W] ? -z : z;
    mm = mx;
    if (my > mm) mm = my;
    if (mz > mm) mm = mz;
    s = '0;
    for (int i = EDGE_BITS; i <= COORD_W; i++) begin
      if (mm[i]) s = 6'(i - EDGE_BITS + 1);
    end
    sx = mx >> s;
    sy = my >> s;
    sz = mz >> s;
    r.x = x[COORD_W] ? -$signed({1'b0, sx[EDGE_BITS-1:0]}) : $signed({1'b0, sx[EDGE_BITS-1:0]});
    r.y = y[COORD_W] ? -$signed({1'b0, sy[EDGE_BITS-1:0]}) : $signed({1'b0, sy[EDGE_BITS-1:0]});
    r.z = z[COORD_W] ? -$signed({1'b0, sz[EDGE_BITS-1:0]}) : $signed({1'b0, sz[EDGE_BITS-1:0]});
    return r;
  endfunction

  always_comb begin
    va[0] = tri_i.first_x;  va[1] = tri_i.first_y;  va[2] = tri_i.first_z;
    vb[0] = tri_i.second_x; vb[1] = tri_i.second_y; vb[2] = tri_i.second_z;
    vc[0] = tri_i.third_x;  vc[1] = tri_i.third_y;  vc[2] = tri_i.third_z;
    for (int i = 0; i < 3; i++) begin
      if (tri_i.starts_new_mesh || !box_valid_r) begin
        lo_nxt[i] = va[i];
        hi_nxt[i] = va[i];
      end else begin
        lo_nxt[i] = (va[i] < lo_r[i]) ? va[i] : lo_r[i];
        hi_nxt[i] = (va[i] > hi_r[i]) ? va[i] : hi_r[i];
      end
      if (vb[i] < lo_nxt[i]) lo_nxt[i] = vb[i];
      if (vb[i] > hi_nxt[i]) hi_nxt[i] = vb[i];
      if (vc[i] < lo_nxt[i]) lo_nxt[i] = vc[i];
      if (vc[i] > hi_nxt[i]) hi_nxt[i] = vc[i];
    end
    job_o.e1 = fit_edge((COORD_W+1)'(vb[0]) - (COORD_W+1)'(va[0]),
                        (COORD_W+1)'(vb[1]) - (COORD_W+1)'(va[1]),
                        (COORD_W+1)'(vb[2]) - (COORD_W+1)'(va[2]));
    job_o.e2 = fit_edge((COORD_W+1)'(vc[0]) - (COORD_W+1)'(va[0]),
                        (COORD_W+1)'(vc[1]) - (COORD_W+1)'(va[1]),
                        (COORD_W+1)'(vc[2]) - (COORD_W+1)'(va[2]));
    job_o.min_x = lo_nxt[0]; job_o.min_y = lo_nxt[1]; job_o.min_z = lo_nxt[2];
    job_o.max_x = hi_nxt[0]; job_o.max_y = hi_nxt[1]; job_o.max_z = hi_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= '0;
        hi_r[i] <= '0;
      end
    end else if (take_i) begin
      box_valid_r <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= lo_nxt[i];
        hi_r[i] <= hi_nxt[i];
      end
    end
  end

endmodule

>>> src/tfsb_queue.sv
// Two-entry queue of jobs between front and back.
`timescale 1ns / 1ps
module tfsb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  tfsb_pkg::job_t      job_i,
  input  logic                pop_i,
  output tfsb_pkg::job_t      job_o,
  output tfsb_pkg::q_status_t stat_o
);
  import tfsb_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= job_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push_i) wr_ptr_r <= ~wr_ptr_r;
      if (pop_i)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push_i) - 2'(pop_i);
    end
  end

  assign job_o        = mem_r[rd_ptr_r];
  assign stat_o.full  = (count_r == 2'd2);
  assign stat_o.empty = (count_r == 2'd0);

endmodule

>>> src/tfsb_back.sv
// Back end: normal, length, cosine and shade sequencer with result register.
`timescale 1ns / 1ps
module tfsb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tfsb_pkg::cfg_t      cfg_i,
  input  tfsb_pkg::job_t      job_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid,
  input  logic                out_ready,
  output tfsb_pkg::out_t      out_data
);
  import tfsb_pkg::*;

  back_state_t state_r, state_nxt;
  job_t                      job_r;
  logic signed [PROD_W-1:0]  p_r [6];
  logic signed [CROSS_W-1:0] c_r [3];
  logic signed [NORM_W-1:0]  n_r [3];
  logic [SQ_W-1:0]           x_r;
  logic [SQ_W-1:0]           r_r;
  logic signed [DOT_W-1:0]   dot_r;
  logic [NUM_W-1:0]          rem_r;
  logic [Q_W-1:0]            q_r;
  logic [CNT_W-1:0]          k_r;
  logic [COLOR_W-1:0]        inten_r;
  logic                      out_valid_r;
  out_t                      out_r;
  logic                      load_out;
  logic                      last_step;
  logic [SQ_W-1:0]           bit_v;
  logic [NUM_W-1:0]          dsh;
  logic [NUM_W-1:0]          num;
  logic [Q_W-1:0]            cosq;
  logic [COLOR_W+Q_W-1:0]    dg;
  logic [COLOR_W+1:0]        isum;
  logic [2*COLOR_W-1:0]      pr, pg, pb;
  logic signed [NORM_W-1:0]  nf [3];
  logic [NORM_BITS-1:0]      nm [3];

  function automatic logic signed [NORM_W-1:0] fit_n(input logic signed [CROSS_W-1:0] v,
                                                      input logic [5:0] s);
    logic [CROSS_W-1:0] m;
    logic [CROSS_W-1:0] sh;
    m  = v[CROSS_W-1] ? -v : v;
    sh = m >> s;
    return v[CROSS_W-1] ? -$signed({1'b0, sh[NORM_BITS-1:0]})
                        : $signed({1'b0, sh[NORM_BITS-1:0]});
  endfunction

  function automatic logic [5:0] norm_shift(input logic signed [CROSS_W-1:0] a,
                                            input logic signed [CROSS_W-1:0] b,
                                            input logic signed [CROSS_W-1:0] c);
    logic [CROSS_W-1:0] ma, mb, mc, mm;
    logic [5:0]         s;
    ma = a[CROSS_W-1] ? -a : a;
    mb = b[CROSS_W-1] ? -b : b;
    mc = c[CROSS_W-1] ? -c : c;
    mm = ma;
    if (mb > mm) mm = mb;
    if (mc > mm) mm = mc;
    s = '0;
    for (int i = NORM_BITS; i < CROSS_W; i++) begin
      if (mm[i]) s = 6'(i - NORM_BITS + 1);
    end
    return s;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nf[i] = fit_n(c_r[i], norm_shift(c_r[0], c_r[1], c_r[2]));
      nm[i] = n_r[i][NORM_W-1] ? NORM_BITS'(-n_r[i]) : NORM_BITS'(n_r[i]);
    end
    bit_v = SQ_W'(1) << {k_r, 1'b0};
    dsh   = NUM_W'(r_r[ROOT_W-1:0]) << k_r;
    num   = NUM_W'(unsigned'(dot_r)) << 1;
    cosq  = (q_r > Q_W'(COS_ONE)) ? Q_W'(COS_ONE) : q_r;
    dg    = cfg_i.diffuse * cosq;
    isum  = (COLOR_W+2)'(cfg_i.ambient) + (COLOR_W+2)'(dg >> COLOR_W);
    pr    = cfg_i.red * inten_r;
    pg    = cfg_i.green * inten_r;
    pb    = cfg_i.blue * inten_r;
    last_step = (k_r == '0);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:   if (!empty_i) state_nxt = B_PROD;
      B_PROD:   state_nxt = B_CROSS;
      B_CROSS:  state_nxt = B_FIT;
      B_FIT:    state_nxt = B_SQDOT;
      B_SQDOT:  state_nxt = B_SQRT;
      B_SQRT:   if (last_step) state_nxt = B_DIVSET;
      B_DIVSET: begin
        if (r_r == '0 || dot_r <= 0 || num >= (NUM_W'(r_r[ROOT_W-1:0]) << Q_W))
          state_nxt = B_INTEN;
        else
          state_nxt = B_DIV;
      end
      B_DIV:    if (last_step) state_nxt = B_INTEN;
      B_INTEN:  state_nxt = B_COLOR;
      B_COLOR:  if (load_out) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o    = (state_r == B_IDLE) && !empty_i;
    load_out = (state_r == B_COLOR) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: if (pop_o) job_r <= job_i;
      B_PROD: begin
        p_r[0] <= job_r.e1.y * job_r.e2.z;
        p_r[1] <= job_r.e1.z * job_r.e2.y;
        p_r[2] <= job_r.e1.z * job_r.e2.x;
        p_r[3] <= job_r.e1.x * job_r.e2.z;
        p_r[4] <= job_r.e1.x * job_r.e2.y;
        p_r[5] <= job_r.e1.y * job_r.e2.x;
      end
      B_CROSS: begin
        c_r[0] <= CROSS_W'(p_r[0]) - CROSS_W'(p_r[1]);
        c_r[1] <= CROSS_W'(p_r[2]) - CROSS_W'(p_r[3]);
        c_r[2] <= CROSS_W'(p_r[4]) - CROSS_W'(p_r[5]);
      end
      B_FIT: for (int i = 0; i < 3; i++) n_r[i] <= nf[i];
      B_SQDOT: begin
        x_r   <= SQ_W'(nm[0] * nm[0]) + SQ_W'(nm[1] * nm[1]) + SQ_W'(nm[2] * nm[2]);
        r_r   <= '0;
        k_r   <= CNT_W'(ROOT_W - 1);
        dot_r <= DOT_W'(n_r[0] * cfg_i.light_x) + DOT_W'(n_r[1] * cfg_i.light_y)
               + DOT_W'(n_r[2] * cfg_i.light_z);
      end
      B_SQRT: begin
        if (x_r >= r_r + bit_v) begin
          x_r <= x_r - (r_r + bit_v);
          r_r <= (r_r >> 1) + bit_v;
        end else begin
          r_r <= r_r >> 1;
        end
        if (!last_step) k_r <= k_r - 1'b1;
      end
      B_DIVSET: begin
        rem_r <= num;
        k_r   <= CNT_W'(Q_W - 1);
        if (r_r == '0 || dot_r <= 0) q_r <= '0;
        else if (num >= (NUM_W'(r_r[ROOT_W-1:0]) << Q_W)) q_r <= Q_W'(COS_ONE);
        else q_r <= '0;
      end
      B_DIV: begin
        if (rem_r >= dsh) begin
          rem_r    <= rem_r - dsh;
          q_r[k_r] <= 1'b1;
        end
        if (!last_step) k_r <= k_r - 1'b1;
      end
      B_INTEN: inten_r <= isum[COLOR_W+1:COLOR_W] != '0 ? '1 : isum[COLOR_W-1:0];
      default: ;
    endcase
    if (load_out) begin
      out_r.shade_red   <= pr[2*COLOR_W-1:COLOR_W];
      out_r.shade_green <= pg[2*COLOR_W-1:COLOR_W];
      out_r.shade_blue  <= pb[2*COLOR_W-1:COLOR_W];
      out_r.box_min_x   <= job_r.min_x;
      out_r.box_min_y   <= job_r.min_y;
      out_r.box_min_z   <= job_r.min_z;
      out_r.box_max_x   <= job_r.max_x;
      out_r.box_max_y   <= job_r.max_y;
      out_r.box_max_z   <= job_r.max_z;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> src/triangle_flat_shade_bounds.sv
// Top level of the triangle flat shade and running bounding box block.
`timescale 1ns / 1ps
// Usage:
//  - in_*: one triangle per transfer (three Q16.16 vertices and a new-mesh
//    flag). in_ready drops only while the two-entry job queue is full.
//  - out_*: one result per triangle, in order: Lambert shade per channel
//    (Q0.16, saturated) and the bounding box including that triangle.
//  - APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready): eight registers
//    at byte offsets 0x00..0x1C; user must write only while idle (not enforced).
// Sequence:
//  - The front updates the box and scales the edges in the cycle of the
//    transfer. The back sequencer then steps through pop, products, cross,
//    scaling, squares and dot, the one-bit-pair-a-cycle square root, divide
//    setup, the restoring divide of the cosine, intensity and color. A zero
//    or clamped cosine skips the divide. The sequencer takes no new triangle
//    until it loads its result, so it sets the rate; later jobs wait in the
//    queue.
// Reset: synchronous, active low; clears the box, the queue, the sequencer
//  and the result valid, and loads the default light and colors.
// Stall: a held result keeps the sequencer in its final step; the queue
//  takes two more triangles before in_ready drops.
module triangle_flat_shade_bounds (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tfsb_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tfsb_pkg::out_t                 out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tfsb_pkg::ADDR_W-1:0]    paddr,
  input  logic [tfsb_pkg::DATA_W-1:0]    pwdata,
  output logic [tfsb_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import tfsb_pkg::*;

  cfg_t      cfg_r;
  job_t      front_job;
  job_t      head_job;
  q_status_t q_stat;
  logic      push;
  logic      pop;
  logic      cfg_wr;
  reg_idx_t  idx;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_x <= RST_LIGHT_X;
      cfg_r.light_y <= RST_LIGHT_Y;
      cfg_r.light_z <= RST_LIGHT_Z;
      cfg_r.ambient <= RST_AMBIENT;
      cfg_r.diffuse <= RST_DIFFUSE;
      cfg_r.red     <= RST_RED;
      cfg_r.green   <= RST_GREEN;
      cfg_r.blue    <= RST_BLUE;
    end else if (cfg_wr) begin
      case (idx)
        REG_LIGHT_X: cfg_r.light_x <= pwdata[LIGHT_W-1:0];
        REG_LIGHT_Y: cfg_r.light_y <= pwdata[LIGHT_W-1:0];
        REG_LIGHT_Z: cfg_r.light_z <= pwdata[LIGHT_W-1:0];
        REG_AMBIENT: cfg_r.ambient <= pwdata[COLOR_W-1:0];
        REG_DIFFUSE: cfg_r.diffuse <= pwdata[COLOR_W-1:0];
        REG_RED:     cfg_r.red     <= pwdata[COLOR_W-1:0];
        REG_GREEN:   cfg_r.green   <= pwdata[COLOR_W-1:0];
        REG_BLUE:    cfg_r.blue    <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // light components read back sign extended
  always_comb begin
    case (idx)
      REG_LIGHT_X: prdata = DATA_W'(cfg_r.light_x);
      REG_LIGHT_Y: prdata = DATA_W'(cfg_r.light_y);
      REG_LIGHT_Z: prdata = DATA_W'(cfg_r.light_z);
      REG_AMBIENT: prdata = DATA_W'(cfg_r.ambient);
      REG_DIFFUSE: prdata = DATA_W'(cfg_r.diffuse);
      REG_RED:     prdata = DATA_W'(cfg_r.red);
      REG_GREEN:   prdata = DATA_W'(cfg_r.green);
      REG_BLUE:    prdata = DATA_W'(cfg_r.blue);
      default:     prdata = '0;
    endcase
  end

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  tfsb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .take_i (push),
    .tri_i  (in_data),
    .job_o  (front_job)
  );

  tfsb_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .job_i  (front_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (q_stat)
  );

  tfsb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg_r),
    .job_i     (head_job),
    .empty_i   (q_stat.empty),
    .pop_o     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("queue popped while empty");
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty)) else $error("queue full and empty");
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result valid after reset");
  a_pop_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full && !pop |=> q_stat.full) else $error("queue lost an entry");
`endif

endmodule
